### rtl/rmq_pkg.sv
package rmq_pkg;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_01;
        logic signed [15:0] rot_02;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_11;
        logic signed [15:0] rot_12;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
        logic               pose_ok;
        logic               device_present;
    } t_rot_in;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic               result_valid;
    } t_quat_out;

    localparam int unsigned SQRT_STAGES = 16;
    localparam int unsigned DIV_STAGES  = 31;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

endpackage

### rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion, Shepperd's method, signed Q2.14.
// Input channel: i_valid / o_stall with i_data carrying the nine matrix
// elements and the pose_ok / device_present flags. Output channel:
// o_valid / i_stall with o_data carrying quat_w..quat_z and result_valid.
// A transfer happens at a rising edge with valid high and stall low.
// If either flag is clear the result is invalid with all components zero.
// Pipeline: one input stage, 16 square-root stages (one result bit each),
// one setup stage, 31 divide stages (one quotient bit each, three dividers
// side by side) and the output register, in that order.
// Throughput: one matrix per cycle while the output is not stalled;
// the pipeline length sets the latency.
// When the receiver stalls a valid result, the whole pipeline freezes and
// o_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (synchronous, active low) clears all stage valid bits.
module rotation_matrix_to_quaternion (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rmq_pkg::t_rot_in   i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output rmq_pkg::t_quat_out o_data
);
    import rmq_pkg::*;

    typedef struct packed {
        logic             vld;
        logic             ok;
        logic [1:0]       br;
        logic [31:0]      rad;
        logic [17:0]      rem;
        logic [15:0]      root;
        logic [2:0][16:0] num;
    } t_sq;

    typedef struct packed {
        logic             vld;
        logic             ok;
        logic [1:0]       br;
        logic [15:0]      diag;
        logic [16:0]      s;
        logic [2:0]       neg;
        logic [2:0][30:0] num;
        logic [2:0][16:0] rem;
        logic [2:0][30:0] quo;
    } t_dv;

    t_sq       r_sq [SQRT_STAGES+1];
    t_dv       r_dv [DIV_STAGES+1];
    t_quat_out r_out;
    logic      r_out_vld;
    logic      en;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    function automatic logic [16:0] s_10_pad(input logic signed [16:0] v);
        return v;
    endfunction

    // input stage: branch pick, radicand, numerators
    logic signed [17:0] tr;
    logic [1:0]         br;
    logic signed [18:0] a;
    logic signed [16:0] d_21_12, d_02_20, d_10_01, s_01_10, s_02_20, s_12_21;
    t_sq                n_sq0;

    always_comb begin
        tr = 18'(i_data.rot_00) + 18'(i_data.rot_11) + 18'(i_data.rot_22);
        if (tr > 18'sd0) begin
            br = BR_TRACE;
        end else if (i_data.rot_00 > i_data.rot_11 && i_data.rot_00 > i_data.rot_22) begin
            br = BR_X;
        end else if (i_data.rot_11 > i_data.rot_22) begin
            br = BR_Y;
        end else begin
            br = BR_Z;
        end
        d_21_12 = 17'(i_data.rot_21) - 17'(i_data.rot_12);
        d_02_20 = 17'(i_data.rot_02) - 17'(i_data.rot_20);
        d_10_01 = 17'(i_data.rot_10) - 17'(i_data.rot_01);
        s_01_10 = 17'(i_data.rot_01) + 17'(i_data.rot_10);
        s_02_20 = 17'(i_data.rot_02) + 17'(i_data.rot_20);
        s_12_21 = 17'(i_data.rot_12) + 17'(i_data.rot_21);
        case (br)
            BR_TRACE: begin
                a = 19'sd16384 + 19'(tr);
                n_sq0.num = {s_10_pad(d_10_01), s_10_pad(d_02_20), s_10_pad(d_21_12)};
            end
            BR_X: begin
                a = 19'sd16384 + 19'(i_data.rot_00) - 19'(i_data.rot_11)
                    - 19'(i_data.rot_22);
                n_sq0.num = {s_10_pad(s_02_20), s_10_pad(s_01_10), s_10_pad(d_21_12)};
            end
            BR_Y: begin
                a = 19'sd16384 + 19'(i_data.rot_11) - 19'(i_data.rot_00)
                    - 19'(i_data.rot_22);
                n_sq0.num = {s_10_pad(s_12_21), s_10_pad(s_01_10), s_10_pad(d_02_20)};
            end
            default: begin
                a = 19'sd16384 + 19'(i_data.rot_22) - 19'(i_data.rot_00)
                    - 19'(i_data.rot_11);
                n_sq0.num = {s_10_pad(s_12_21), s_10_pad(s_02_20), s_10_pad(d_10_01)};
            end
        endcase
        n_sq0.vld  = i_valid;
        n_sq0.ok   = i_data.pose_ok && i_data.device_present;
        n_sq0.br   = br;
        n_sq0.rad  = a[18] ? 32'd0 : {a[17:0], 14'd0};
        n_sq0.rem  = '0;
        n_sq0.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq[0].vld <= 1'b0;
        end else if (en) begin
            r_sq[0] <= n_sq0;
        end
    end

    // square root, two radicand bits per stage
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sq
        logic [19:0] rem4, trial;
        t_sq         n_sq;
        always_comb begin
            rem4  = {r_sq[k].rem, r_sq[k].rad[31:30]};
            trial = {2'd0, r_sq[k].root, 2'b01};
            n_sq     = r_sq[k];
            n_sq.rad = {r_sq[k].rad[29:0], 2'd0};
            if (rem4 >= trial) begin
                n_sq.rem  = 18'(rem4 - trial);
                n_sq.root = {r_sq[k].root[14:0], 1'b1};
            end else begin
                n_sq.rem  = rem4[17:0];
                n_sq.root = {r_sq[k].root[14:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[k+1].vld <= 1'b0;
            end else if (en) begin
                r_sq[k+1] <= n_sq;
            end
        end
    end

    // divider setup: magnitudes of numerator * 2^14, divisor s = 2r
    t_dv n_dv0;
    always_comb begin
        n_dv0.vld  = r_sq[SQRT_STAGES].vld;
        n_dv0.ok   = r_sq[SQRT_STAGES].ok;
        n_dv0.br   = r_sq[SQRT_STAGES].br;
        n_dv0.diag = {1'b0, r_sq[SQRT_STAGES].root[15:1]};
        n_dv0.s    = {r_sq[SQRT_STAGES].root, 1'b0};
        n_dv0.rem  = '0;
        n_dv0.quo  = '0;
        for (int j = 0; j < 3; j++) begin
            n_dv0.neg[j] = r_sq[SQRT_STAGES].num[j][16];
            n_dv0.num[j] = r_sq[SQRT_STAGES].num[j][16]
                ? {17'(-r_sq[SQRT_STAGES].num[j]), 14'd0}
                : {r_sq[SQRT_STAGES].num[j], 14'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].vld <= 1'b0;
        end else if (en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // restoring division, one quotient bit per stage per lane
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_dv
        t_dv         n_dv;
        logic [17:0] rem2 [3];
        always_comb begin
            n_dv = r_dv[k];
            for (int j = 0; j < 3; j++) begin
                rem2[j]       = {r_dv[k].rem[j], r_dv[k].num[j][30]};
                n_dv.num[j]   = {r_dv[k].num[j][29:0], 1'b0};
                if (rem2[j] >= {1'b0, r_dv[k].s}) begin
                    n_dv.rem[j] = 17'(rem2[j] - {1'b0, r_dv[k].s});
                    n_dv.quo[j] = {r_dv[k].quo[j][29:0], 1'b1};
                end else begin
                    n_dv.rem[j] = rem2[j][16:0];
                    n_dv.quo[j] = {r_dv[k].quo[j][29:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1].vld <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= n_dv;
            end
        end
    end

    // sign, saturate and place the components
    logic [15:0] q [3];
    t_quat_out   n_out;
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (r_dv[DIV_STAGES].neg[j]) begin
                q[j] = (r_dv[DIV_STAGES].quo[j] > 31'd32768) ? 16'h8000
                     : 16'(~r_dv[DIV_STAGES].quo[j] + 31'd1);
            end else begin
                q[j] = (r_dv[DIV_STAGES].quo[j] > 31'd32767) ? 16'h7fff
                     : r_dv[DIV_STAGES].quo[j][15:0];
            end
        end
        case (r_dv[DIV_STAGES].br)
            BR_TRACE: n_out = {r_dv[DIV_STAGES].diag, q[0], q[1], q[2], 1'b1};
            BR_X:     n_out = {q[0], r_dv[DIV_STAGES].diag, q[1], q[2], 1'b1};
            BR_Y:     n_out = {q[0], q[1], r_dv[DIV_STAGES].diag, q[2], 1'b1};
            default:  n_out = {q[0], q[1], q[2], r_dv[DIV_STAGES].diag, 1'b1};
        endcase
        if (!r_dv[DIV_STAGES].ok) begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv[DIV_STAGES].vld;
            r_out     <= n_out;
        end
    end

endmodule

### rtl/rmq_check.sv
module rmq_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input rmq_pkg::t_quat_out o_data,
    input logic               o_valid,
    input logic               i_stall
);
    import rmq_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.result_valid |-> o_data.quat_w == 16'sd0 &&
        o_data.quat_x == 16'sd0 && o_data.quat_y == 16'sd0 && o_data.quat_z == 16'sd0)
        else $error("invalid result with nonzero components");

    a_nonzero_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.result_valid |-> !(o_data.quat_w == 16'sd0 &&
        o_data.quat_x == 16'sd0 && o_data.quat_y == 16'sd0 && o_data.quat_z == 16'sd0))
        else $error("valid result with all components zero");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while output blocked");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_check u_rmq_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_data  (o_data),
    .o_valid (o_valid),
    .i_stall (i_stall)
);
